// ===== hdl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// types and constants shared by the homogeneous point transform
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int PROD_W   = 64;
	localparam int SUM_W    = 66;
	localparam int RES_W    = 52;
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = 31;
	localparam int OVF_SH   = QUO_W - FRAC_W;

	localparam logic [DATA_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic               is_direction;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               error_flag;
	} out_req_t;

	typedef struct packed {
		logic              dir;
		logic              wzero;
		logic [2:0]        ovf;
		logic [2:0]        neg;
		logic [2:0][31:0]  dres;
		logic              derr;
	} side_t;

endpackage

// ===== hdl/hpt_divider.sv =====
// ----------------------------------------------------------------------------
// hpt_divider
// pipelined restoring divider, one quotient bit per stage, computes
// floor(n * 2^16 / d) for quotients below 2^31
// ----------------------------------------------------------------------------
module hpt_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hpt_pkg::RES_W-1:0]   n,
	input  logic [hpt_pkg::RES_W-1:0]   d,
	output logic [hpt_pkg::QUO_W-1:0]   q
);
	import hpt_pkg::*;

	logic [RES_W-1:0]  rem_s [QUO_W];
	logic [RES_W-1:0]  d_s   [QUO_W];
	logic [OVF_SH-1:0] nlo_s [QUO_W];
	logic [QUO_W-1:0]  q_s   [QUO_W];

	logic [RES_W-1:0]  rem_in [QUO_W];
	logic [RES_W-1:0]  d_in   [QUO_W];
	logic [OVF_SH-1:0] nlo_in [QUO_W];
	logic [QUO_W-1:0]  q_in   [QUO_W];

	always_comb begin
		rem_in[0] = RES_W'(n >> OVF_SH);
		d_in[0]   = d;
		nlo_in[0] = n[OVF_SH-1:0];
		q_in[0]   = '0;
		for (int k = 1; k < QUO_W; k++) begin
			rem_in[k] = rem_s[k-1];
			d_in[k]   = d_s[k-1];
			nlo_in[k] = nlo_s[k-1];
			q_in[k]   = q_s[k-1];
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [RES_W:0] t;
		logic           ge;
		assign t  = {rem_in[k], nlo_in[k][OVF_SH-1]};
		assign ge = t >= {1'b0, d_in[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RES_W'(t - {1'b0, d_in[k]}) : RES_W'(t);
				d_s[k]   <= d_in[k];
				nlo_s[k] <= {nlo_in[k][OVF_SH-2:0], 1'b0};
				q_s[k]   <= {q_in[k][QUO_W-2:0], ge};
			end
		end
	end

	assign q = q_s[QUO_W-1];

endmodule

// ===== hdl/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of a Q16.16 vector with perspective divide
// ----------------------------------------------------------------------------
//  port group  | direction | handshake
//  in_*        | in        | in_valid / in_stall
//  out_*       | out       | out_valid / out_stall
//  apb         | in        | psel / penable / pwrite, pready tied high
//
//  one request per cycle unless out_stall holds the pipeline; stages: multiply, sum,
//  prepare, 31 divider stages (one quotient bit each), output register
//  out_stall while out_valid freezes the whole pipeline; no request is lost or repeated
//  reset loads the identity matrix and empties the pipeline
// ----------------------------------------------------------------------------
module homogeneous_point_transform (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hpt_pkg::in_req_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hpt_pkg::out_req_t            out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hpt_pkg::ADDR_W-1:0]   paddr,
	input  logic [hpt_pkg::DATA_W-1:0]   pwdata,
	output logic [hpt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import hpt_pkg::*;

	localparam logic signed [RES_W-1:0] QMAX_R = RES_W'(64'sd2147483647);
	localparam logic signed [RES_W-1:0] QMIN_R = RES_W'(-64'sd2147483648);

	logic [DATA_W-1:0] cfg_q [NUM_REGS];
	logic              en;

	assign pready = 1'b1;
	assign prdata = cfg_q[paddr[ADDR_W-1:3]];
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
		end else if (psel && penable && pwrite) begin
			cfg_q[paddr[ADDR_W-1:3]] <= pwdata;
		end
	end

	logic signed [31:0] coef [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				coef[r][c] = cfg_q[2*r + c/2][(c%2)*32 +: 32];
	end

	// stage 1: products
	logic signed [PROD_W-1:0] prod_s1 [4][3];
	logic                     dir_s1;
	logic                     v_s1;
	logic signed [31:0]       vec [3];
	assign vec[0] = in_data.in_x;
	assign vec[1] = in_data.in_y;
	assign vec[2] = in_data.in_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= coef[r][c] * vec[c];
			dir_s1 <= in_data.is_direction;
		end
	end

	// stage 2: row sums, rounding, translation
	logic signed [RES_W-1:0] res_s2 [4];
	logic                    dir_s2;
	logic                    v_s2;
	logic signed [SUM_W-1:0] sum [4];
	logic signed [SUM_W-1:0] rnd [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1]) + SUM_W'(prod_s1[r][2]);
			rnd[r] = (sum[r] + SUM_W'(32768)) >>> FRAC_W;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				res_s2[r] <= RES_W'(rnd[r]) + (dir_s1 ? RES_W'(0) : RES_W'(coef[r][3]));
			dir_s2 <= dir_s1;
		end
	end

	// stage 3: clamp for directions, magnitudes and overflow check for points
	logic [RES_W-1:0] n_s3 [3];
	logic [RES_W-1:0] d_s3;
	side_t            side_s3;
	logic             v_s3;
	logic [RES_W-1:0] n_c [3];
	logic [RES_W-1:0] d_c;
	side_t            side_c;

	always_comb begin
		d_c          = res_s2[3][RES_W-1] ? RES_W'(-res_s2[3]) : RES_W'(res_s2[3]);
		side_c.dir   = dir_s2;
		side_c.wzero = res_s2[3] == '0;
		side_c.derr  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			n_c[i] = res_s2[i][RES_W-1] ? RES_W'(-res_s2[i]) : RES_W'(res_s2[i]);
			side_c.neg[i] = res_s2[i][RES_W-1] ^ res_s2[3][RES_W-1];
			side_c.ovf[i] = (RES_W+OVF_SH)'(n_c[i]) >= {d_c, OVF_SH'(0)};
			if (res_s2[i] > QMAX_R) begin
				side_c.dres[i] = 32'h7fff_ffff;
				side_c.derr    = 1'b1;
			end else if (res_s2[i] < QMIN_R) begin
				side_c.dres[i] = 32'h8000_0000;
				side_c.derr    = 1'b1;
			end else begin
				side_c.dres[i] = res_s2[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= n_c;
			d_s3    <= d_c;
			side_s3 <= side_c;
		end
	end

	// divider stages
	logic [QUO_W-1:0] quo [3];
	for (genvar i = 0; i < 3; i++) begin : g_div
		hpt_divider u_div (
			.clk (clk),
			.en  (en),
			.n   (n_s3[i]),
			.d   (d_s3),
			.q   (quo[i])
		);
	end

	side_t side_d [QUO_W];
	logic  v_d    [QUO_W];
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s3;
			for (int k = 1; k < QUO_W; k++) side_d[k] <= side_d[k-1];
		end
	end

	// output register
	side_t    sd;
	out_req_t res_c;
	logic [31:0] pt [3];
	assign sd = side_d[QUO_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sd.ovf[i]) pt[i] = sd.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
			else if (sd.neg[i]) pt[i] = 32'(0) - {1'b0, quo[i]};
			else pt[i] = {1'b0, quo[i]};
		end
		if (sd.dir) begin
			res_c.out_x      = sd.dres[0];
			res_c.out_y      = sd.dres[1];
			res_c.out_z      = sd.dres[2];
			res_c.error_flag = sd.derr;
		end else if (sd.wzero) begin
			res_c.out_x      = '0;
			res_c.out_y      = '0;
			res_c.out_z      = '0;
			res_c.error_flag = 1'b1;
		end else begin
			res_c.out_x      = pt[0];
			res_c.out_y      = pt[1];
			res_c.out_z      = pt[2];
			res_c.error_flag = |sd.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			for (int k = 0; k < QUO_W; k++) v_d[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_d[0]    <= v_s3;
			for (int k = 1; k < QUO_W; k++) v_d[k] <= v_d[k-1];
			out_valid <= v_d[QUO_W-1];
		end
	end

endmodule

// ===== hdl/hpt_checker.sv =====
// ----------------------------------------------------------------------------
// hpt_checker
// port level checks of the homogeneous point transform
// ----------------------------------------------------------------------------
module hpt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input hpt_pkg::out_req_t out_data,
	input logic              pready
);
	import hpt_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request taken while pipeline frozen");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall && pready)
		else $error("input stalled without output back pressure");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.pready    (pready)
);
